/* src/sha256_pkg.sv */
// shared types, constants and round functions for the sha-256 byte stream hasher
`default_nettype none
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_PAD_ZERO,
    CMD_FINISH
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data_byte;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } back_state_e;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [63:0][31:0] RoundK = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned r);
    ror = (x >> r) | (x << (32 - r));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage
`default_nettype wire

/* src/sha256_front.sv */
// front part: classifies input transfers into commands for the back part
`default_nettype none
module sha256_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  sha256_pkg::in_item_t in_data_i,
  output logic                 cmd_valid_o,
  input  wire                  cmd_ready_i,
  output sha256_pkg::cmd_t     cmd_o
);
  import sha256_pkg::*;

  logic  valid_q, valid_d;
  cmd_t  cmd_q, cmd_d;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d        = 1'b1;
      cmd_d.kind     = in_data_i.func ? CMD_FINISH : CMD_DATA;
      cmd_d.data_byte = in_data_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule
`default_nettype wire

/* src/sha256_queue.sv */
// short command queue between front and back
`default_nettype none
module sha256_queue #(
  parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_valid_i,
  output logic              push_ready_o,
  input  sha256_pkg::cmd_t  push_data_i,
  output logic              pop_valid_o,
  input  wire               pop_ready_i,
  output sha256_pkg::cmd_t  pop_data_o
);
  import sha256_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != (AW+1)'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue count beyond depth");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (AW+1)'(Depth) && !pop) |=> cnt_q == (AW+1)'(Depth))
    else $error("full queue changed without pop");
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q)) else $error("empty queue pointers differ");
`endif

endmodule
`default_nettype wire

/* src/sha256_back.sv */
// back part: block buffer, padding, 64-round compression and digest output
`default_nettype none
module sha256_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cmd_valid_i,
  output logic                  cmd_ready_o,
  input  sha256_pkg::cmd_t      cmd_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output sha256_pkg::out_item_t out_data_o
);
  import sha256_pkg::*;

  back_state_e       state_q, state_d;
  logic [15:0][31:0] w_q;
  logic [5:0]        fill_q;
  logic [60:0]       len_q;
  hash_t             h_q, v_q;
  logic [5:0]        rnd_q;
  logic              fin_q;
  logic              skip_q;
  logic              skip_now;
  logic              pad_done_q;
  logic [2:0]        idx_q;
  logic [31:0]       w_new, t1, t2;
  logic [63:0]       bits;
  logic              take;
  logic [7:0]        pbyte;

  assign bits = {len_q, 3'b000};
  assign cmd_ready_o = (state_q == ST_FILL);
  assign take = cmd_valid_i && cmd_ready_o;
  assign skip_now = skip_q || (!pad_done_q && fill_q >= LenStart);

  // byte written during padding
  always_comb begin
    if (!pad_done_q) begin
      pbyte = PadByte;
    end else if (fill_q >= LenStart && !skip_q) begin
      pbyte = bits[8'(63 - 8 * (fill_q - LenStart)) -: 8];
    end else begin
      pbyte = 8'h00;
    end
  end

  assign w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[rnd_q] + w_q[0];
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: begin
        if (take && cmd_i.kind == CMD_FINISH) begin
          state_d = ST_PAD;
        end else if (take && fill_q == 6'd63) begin
          state_d = ST_ROUND;
        end
      end
      ST_PAD: begin
        if (fill_q == 6'd63) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_q == 6'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (fin_q) begin
          state_d = ST_EMIT;
        end else if (pad_done_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_EMIT: begin
        if (out_ready_i && idx_q == 3'd7) begin
          state_d = ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  assign out_valid_o = (state_q == ST_EMIT);
  assign out_data_o  = '{digest_word: h_q[idx_q], word_index: idx_q,
                         last_word: idx_q == 3'd7};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      fill_q     <= '0;
      len_q      <= '0;
      h_q        <= InitHash;
      v_q        <= '0;
      rnd_q      <= '0;
      fin_q      <= 1'b0;
      skip_q     <= 1'b0;
      pad_done_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_FILL: begin
          if (take && cmd_i.kind == CMD_DATA) begin
            fill_q <= fill_q + 1'b1;
            len_q  <= len_q + 1'b1;
          end
          if (take && cmd_i.kind == CMD_FINISH) begin
            pad_done_q <= 1'b0;
          end
          v_q   <= h_q;
          rnd_q <= '0;
        end
        ST_PAD: begin
          fill_q     <= fill_q + 1'b1;
          pad_done_q <= 1'b1;
          // a marker at byte 56 or later pushes the length into a second block
          if (fill_q == 6'd63) begin
            skip_q <= 1'b0;
            fin_q  <= !skip_now;
          end else if (skip_now) begin
            skip_q <= 1'b1;
          end
          v_q   <= h_q;
          rnd_q <= '0;
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 1'b1;
          v_q   <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
        end
        ST_ADD: begin
          for (int j = 0; j < 8; j++) begin
            h_q[j] <= h_q[j] + v_q[j];
          end
          if (fin_q) begin
            idx_q <= '0;
          end
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == 3'd7) begin
              h_q        <= InitHash;
              fill_q     <= '0;
              len_q      <= '0;
              fin_q      <= 1'b0;
              pad_done_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // message schedule: write bytes in place while filling or padding, then roll
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FILL && take && cmd_i.kind == CMD_DATA) || state_q == ST_PAD) begin
      w_q[fill_q[5:2]][8'(31 - 8 * fill_q[1:0]) -: 8] <=
        (state_q == ST_PAD) ? pbyte : cmd_i.data_byte;
    end else if (state_q == ST_ROUND) begin
      w_q <= {w_new, w_q[15:1]};
    end
  end

`ifndef SYNTHESIS
  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(idx_q)))
    else $error("digest index moved while stalled");
  a_round_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q != 6'd63) |=> state_q == ST_ROUND)
    else $error("round loop left early");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FILL) |-> !cmd_ready_o) else $error("command taken while busy");
`endif

endmodule
`default_nettype wire

/* src/sha256_byte_stream_hasher_unit.sv */
// top level of the sha-256 byte stream hasher
// usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one item per transfer:
//   func 0 absorbs data_byte, func 1 finishes the message.
//   out channel (out_valid_o/out_ready_i/out_data_o) gives eight digest words
//   h0..h7 after each finish, last_word set on h7.
// timing:
//   the back part takes bytes while filling a block; every 64th byte starts a
//   compression of 64 rounds at one per cycle plus the chaining add, and
//   no bytes are taken until it is done.
//   a finish pads each closing block, runs one or two compressions and then
//   presents one digest word per cycle while out_ready_i is high.
//   a front register and a four-entry command queue keep taking input
//   while the back part compresses or waits on a stalled receiver.
// reset:
//   clears the queue, chaining words to the initial hash, length and fill.
//   a stalled receiver holds the current word; input stalls once the
//   queue fills.
`default_nettype none
module sha256_byte_stream_hasher_unit #(
  parameter int unsigned QueueDepth = sha256_pkg::QueueDepth
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  sha256_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output sha256_pkg::out_item_t out_data_o
);
  import sha256_pkg::*;

  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  sha256_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  sha256_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_data_i(f_cmd),
    .pop_valid_o(q_valid), .pop_ready_i(q_ready), .pop_data_o(q_cmd)
  );

  sha256_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire
